@@ rtl/core/tect_pkg.sv @@
// ----------------------------------------------------------------------------
// tect_pkg
// Shared widths, register codes, reset values and arithmetic helpers for the
// triple moving-average coincidence trigger.
// ----------------------------------------------------------------------------
package tect_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COUNT_BITS = 8;

  // Unsigned unit-interval values, signed Q2 samples, product of the two
  localparam int VAL_W    = FRAC_BITS + 1;
  localparam int SAMPLE_W = FRAC_BITS + 2;
  localparam int PROD_W   = 2 * SAMPLE_W;

  localparam int NUM_SAMPLES = 4;
  localparam int IN_DATA_W   = ((NUM_SAMPLES * SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 4 * VAL_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = VAL_W;

  localparam logic [VAL_W-1:0] ONE = VAL_W'(64'd1 << FRAC_BITS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRUST_TH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_TH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HARMONY_TH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = 3'd5;

  // Reset values, rounded to nearest
  localparam logic [VAL_W-1:0] WEIGHT_DEFAULT   = VAL_W'((64'd1 << FRAC_BITS) / 4);
  localparam logic [VAL_W-1:0] TRUST_DEFAULT    =
    VAL_W'(((64'd1 << FRAC_BITS) * 4 + 2) / 5);
  localparam logic [VAL_W-1:0] PRESENCE_DEFAULT =
    VAL_W'(((64'd1 << FRAC_BITS) * 7 + 5) / 10);
  localparam logic [VAL_W-1:0] HARMONY_DEFAULT  =
    VAL_W'(((64'd1 << FRAC_BITS) * 17 + 10) / 20);
  localparam logic [COUNT_BITS-1:0] WARMUP_DEFAULT     = COUNT_BITS'(10);
  localparam logic [COUNT_BITS-1:0] REFRACTORY_DEFAULT = COUNT_BITS'(5);

  // Clamp a signed Q2 sample to 0..ONE
  function automatic logic [VAL_W-1:0] to_unit(input logic [SAMPLE_W-1:0] raw);
    logic [VAL_W-1:0] mag;
    mag = raw[VAL_W-1:0];
    if (raw[SAMPLE_W-1]) begin
      return '0;
    end else if (mag > ONE) begin
      return ONE;
    end
    return mag;
  endfunction

  // Cap a written value at ONE
  function automatic logic [VAL_W-1:0] cap_one(input logic [VAL_W-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

  // avg + floor(w * (x - avg) / ONE), equal to (w*x + (ONE-w)*avg) >> FRAC_BITS
  function automatic logic [VAL_W-1:0] blend(input logic [VAL_W-1:0] avg,
                                             input logic [VAL_W-1:0] x,
                                             input logic [VAL_W-1:0] w);
    logic signed [SAMPLE_W-1:0] diff;
    logic signed [SAMPLE_W-1:0] ws;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   sum;
    diff = $signed({1'b0, x}) - $signed({1'b0, avg});
    ws   = $signed({1'b0, w});
    prod = PROD_W'(diff) * PROD_W'(ws);
    sum  = $signed({{(PROD_W-VAL_W){1'b0}}, avg}) + (prod >>> FRAC_BITS);
    return sum[VAL_W-1:0];
  endfunction

endpackage

@@ rtl/core/triple_ema_coincidence_trigger_top.sv @@
// ----------------------------------------------------------------------------
// triple_ema_coincidence_trigger_top
// An item passes from the input register to the result register.
// Throughput: one item per cycle unless out_tready stalls; one multiply-add per
// average sets the path between the input register and the result register.
// Reset: synchronous, active low; registers take their default values, the
// averages clear and the warmup count loads its default length.
// ----------------------------------------------------------------------------
module triple_ema_coincidence_trigger_top
  import tect_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // trust_sample, presence_sample, harmony_sample, awareness_sample
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // awareness_level, trust_average, presence_average, harmony_average, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // fired
  output logic                  out_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [VAL_W-1:0]      weight_r, trust_th_r, presence_th_r, harmony_th_r;
  logic [COUNT_BITS-1:0] refractory_len_r;

  // Item state
  logic [VAL_W-1:0]      trust_avg_r, presence_avg_r, harmony_avg_r;
  logic                  loaded_r;
  logic [COUNT_BITS-1:0] warmup_left_r, refractory_left_r;

  // Input register
  logic                          in_valid_r;
  logic [NUM_SAMPLES*SAMPLE_W-1:0] in_data_r;

  // Result register
  logic             out_valid_r;
  logic             fired_r;
  logic [VAL_W-1:0] aware_r, trust_out_r, presence_out_r, harmony_out_r;

  logic advance;
  logic [VAL_W-1:0] t_unit, p_unit, h_unit, a_unit;
  logic [VAL_W-1:0] trust_nxt, presence_nxt, harmony_nxt;
  logic [COUNT_BITS-1:0] warmup_nxt, refractory_nxt;
  logic fired_nxt;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Store configuration writes, saturating to the unit interval; a zero weight loads the default
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r         <= WEIGHT_DEFAULT;
      trust_th_r       <= TRUST_DEFAULT;
      presence_th_r    <= PRESENCE_DEFAULT;
      harmony_th_r     <= HARMONY_DEFAULT;
      refractory_len_r <= REFRACTORY_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WEIGHT: begin
          weight_r <= (cfg_wdata == '0) ? WEIGHT_DEFAULT : cap_one(cfg_wdata);
        end
        REG_TRUST_TH:    trust_th_r       <= cap_one(cfg_wdata);
        REG_PRESENCE_TH: presence_th_r    <= cap_one(cfg_wdata);
        REG_HARMONY_TH:  harmony_th_r     <= cap_one(cfg_wdata);
        // The warmup length only seeds the count at reset, where it is the default
        REG_WARMUP: ;
        REG_REFRACTORY:  refractory_len_r <= cfg_wdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Capture the request into the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata[NUM_SAMPLES*SAMPLE_W-1:0];
    end
  end

  // Clamp samples and update the averages
  always_comb begin
    t_unit = to_unit(in_data_r[0*SAMPLE_W +: SAMPLE_W]);
    p_unit = to_unit(in_data_r[1*SAMPLE_W +: SAMPLE_W]);
    h_unit = to_unit(in_data_r[2*SAMPLE_W +: SAMPLE_W]);
    a_unit = to_unit(in_data_r[3*SAMPLE_W +: SAMPLE_W]);
    if (!loaded_r) begin
      trust_nxt    = t_unit;
      presence_nxt = p_unit;
      harmony_nxt  = h_unit;
    end else begin
      trust_nxt    = blend(trust_avg_r, t_unit, weight_r);
      presence_nxt = blend(presence_avg_r, p_unit, weight_r);
      harmony_nxt  = blend(harmony_avg_r, h_unit, weight_r);
    end
  end

  // Suppress during warmup, then refractory; otherwise test the thresholds
  always_comb begin
    warmup_nxt     = warmup_left_r;
    refractory_nxt = refractory_left_r;
    fired_nxt      = 1'b0;
    if (warmup_left_r != '0) begin
      warmup_nxt = warmup_left_r - 1'b1;
    end else if (refractory_left_r != '0) begin
      refractory_nxt = refractory_left_r - 1'b1;
    end else if (trust_nxt >= trust_th_r && presence_nxt >= presence_th_r &&
                 harmony_nxt >= harmony_th_r) begin
      fired_nxt      = 1'b1;
      refractory_nxt = refractory_len_r;
    end
  end

  // Commit state as the item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trust_avg_r       <= '0;
      presence_avg_r    <= '0;
      harmony_avg_r     <= '0;
      loaded_r          <= 1'b0;
      warmup_left_r     <= WARMUP_DEFAULT;
      refractory_left_r <= '0;
    end else if (advance) begin
      trust_avg_r       <= trust_nxt;
      presence_avg_r    <= presence_nxt;
      harmony_avg_r     <= harmony_nxt;
      loaded_r          <= 1'b1;
      warmup_left_r     <= warmup_nxt;
      refractory_left_r <= refractory_nxt;
    end
  end

  // Hold the result until the downstream request is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fired_r        <= fired_nxt;
      aware_r        <= fired_nxt ? a_unit : '0;
      trust_out_r    <= trust_nxt;
      presence_out_r <= presence_nxt;
      harmony_out_r  <= harmony_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = fired_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_FIELD_W){1'b0}},
                       harmony_out_r, presence_out_r, trust_out_r, aware_r};

endmodule

@@ bench/tb_triple_ema_coincidence_trigger_top.sv @@
// ----------------------------------------------------------------------------
// tb_triple_ema_coincidence_trigger_top
// Self-checking bench for the triple moving-average coincidence trigger. A
// behavioural copy of the averages, warmup and refractory counters predicts
// every result, and the bench compares each one field by field. Stimulus is a
// directed opening, then phases of random samples under varied register
// settings and back-pressure on both streams.
// ----------------------------------------------------------------------------
module tb_triple_ema_coincidence_trigger_top;
  import tect_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 205;

  // Indexes that decode to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [SAMPLE_W-1:0] awareness;
    logic [SAMPLE_W-1:0] harmony;
    logic [SAMPLE_W-1:0] presence;
    logic [SAMPLE_W-1:0] trust;
  } sample_set_t;

  typedef struct {
    logic             fired;
    logic [VAL_W-1:0] awareness_level;
    logic [VAL_W-1:0] trust_average;
    logic [VAL_W-1:0] presence_average;
    logic [VAL_W-1:0] harmony_average;
  } trigger_result_t;

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Predicted register contents
  logic [VAL_W-1:0]      weight_q;
  logic [VAL_W-1:0]      trust_min;
  logic [VAL_W-1:0]      presence_min;
  logic [VAL_W-1:0]      harmony_min;
  logic [COUNT_BITS-1:0] holdoff_len;

  // Predicted internal state
  logic [VAL_W-1:0]      trust_ema;
  logic [VAL_W-1:0]      presence_ema;
  logic [VAL_W-1:0]      harmony_ema;
  logic                  ema_primed;
  logic [COUNT_BITS-1:0] warmup_count;
  logic [COUNT_BITS-1:0] holdoff_count;

  sample_set_t     sample_backlog[$];
  sample_set_t     presented_set;
  trigger_result_t pending_results[$];

  int  queued_items;
  int  accepted_items;
  int  error_count;
  int  quiet_cycles;
  int  send_idle_pct;
  int  recv_idle_pct;
  logic in_taken;

  triple_ema_coincidence_trigger_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp a signed Q2 sample into the unit interval
  function automatic logic [VAL_W-1:0] sample_to_unit(input logic [SAMPLE_W-1:0] raw);
    if (raw[SAMPLE_W-1]) begin
      return '0;
    end
    if (raw[VAL_W-1:0] > ONE) begin
      return ONE;
    end
    return raw[VAL_W-1:0];
  endfunction

  // Weighted mix of a new sample into an average, truncated
  function automatic logic [VAL_W-1:0] mix_sample(input logic [VAL_W-1:0] avg,
                                                  input logic [VAL_W-1:0] x);
    logic [63:0] acc;
    acc = 64'(weight_q) * 64'(x) + (64'(ONE) - 64'(weight_q)) * 64'(avg);
    return VAL_W'(acc >> FRAC_BITS);
  endfunction

  // Mirror a register write into the predicted register set
  function automatic void mirror_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_WEIGHT: begin
        weight_q = (val == '0) ? WEIGHT_DEFAULT : ((val > ONE) ? ONE : val);
      end
      REG_TRUST_TH: begin
        trust_min = (val > ONE) ? ONE : val;
      end
      REG_PRESENCE_TH: begin
        presence_min = (val > ONE) ? ONE : val;
      end
      REG_HARMONY_TH: begin
        harmony_min = (val > ONE) ? ONE : val;
      end
      // The warmup length only seeds the count at reset
      REG_WARMUP: begin
      end
      REG_REFRACTORY: begin
        holdoff_len = val[COUNT_BITS-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Advance the predicted trigger by one sample set and return its result
  function automatic trigger_result_t advance_trigger(input sample_set_t s);
    trigger_result_t r;
    logic [VAL_W-1:0] t;
    logic [VAL_W-1:0] p;
    logic [VAL_W-1:0] h;
    logic [VAL_W-1:0] a;
    t = sample_to_unit(s.trust);
    p = sample_to_unit(s.presence);
    h = sample_to_unit(s.harmony);
    a = sample_to_unit(s.awareness);
    if (!ema_primed) begin
      trust_ema    = t;
      presence_ema = p;
      harmony_ema  = h;
      ema_primed   = 1'b1;
    end else begin
      trust_ema    = mix_sample(trust_ema, t);
      presence_ema = mix_sample(presence_ema, p);
      harmony_ema  = mix_sample(harmony_ema, h);
    end
    r.fired = 1'b0;
    if (warmup_count != '0) begin
      warmup_count = warmup_count - 1'b1;
    end else if (holdoff_count != '0) begin
      holdoff_count = holdoff_count - 1'b1;
    end else if (trust_ema >= trust_min && presence_ema >= presence_min &&
                 harmony_ema >= harmony_min) begin
      r.fired = 1'b1;
      holdoff_count = holdoff_len;
    end
    r.awareness_level  = r.fired ? a : '0;
    r.trust_average    = trust_ema;
    r.presence_average = presence_ema;
    r.harmony_average  = harmony_ema;
    return r;
  endfunction

  // Random set; in the high regime the three samples sit near or above one
  function automatic sample_set_t random_set(input bit high);
    sample_set_t s;
    s.trust     = SAMPLE_W'($urandom());
    s.presence  = SAMPLE_W'($urandom());
    s.harmony   = SAMPLE_W'($urandom());
    s.awareness = SAMPLE_W'($urandom());
    if (high) begin
      s.trust    = SAMPLE_W'($urandom_range(131071, 45000));
      s.presence = SAMPLE_W'($urandom_range(131071, 45000));
      s.harmony  = SAMPLE_W'($urandom_range(131071, 45000));
      // Break the coincidence now and then
      if ($urandom_range(99) < 8) begin
        s.harmony = SAMPLE_W'($urandom());
      end
    end
    return s;
  endfunction

  function automatic sample_set_t make_set(input int t, input int p, input int h,
                                           input int a);
    sample_set_t s;
    s.trust     = SAMPLE_W'(t);
    s.presence  = SAMPLE_W'(p);
    s.harmony   = SAMPLE_W'(h);
    s.awareness = SAMPLE_W'(a);
    return s;
  endfunction

  task automatic queue_set(input sample_set_t s);
    sample_backlog.push_back(s);
    queued_items++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    mirror_reg_write(idx, val);
  endtask

  // Hold until every request has been taken and every result returned
  task automatic wait_idle();
    while (accepted_items != queued_items || pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic report_field(input string name, input logic [VAL_W-1:0] want,
                              input logic [VAL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Write all registers, then run one phase of random sample sets
  task automatic run_phase(input logic [CFG_DATA_W-1:0] w,
                           input logic [CFG_DATA_W-1:0] tt,
                           input logic [CFG_DATA_W-1:0] pt,
                           input logic [CFG_DATA_W-1:0] ht,
                           input logic [CFG_DATA_W-1:0] wl,
                           input logic [CFG_DATA_W-1:0] rl,
                           input int sender_pct, input int receiver_pct);
    int  regime_left;
    bit  high;
    wait_idle();
    write_reg(REG_WEIGHT, w);
    write_reg(REG_TRUST_TH, tt);
    write_reg(REG_PRESENCE_TH, pt);
    write_reg(REG_HARMONY_TH, ht);
    write_reg(REG_WARMUP, wl);
    write_reg(REG_REFRACTORY, rl);
    @(negedge clk);
    cfg_we <= 1'b0;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    regime_left = 0;
    high = 1'b0;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (regime_left == 0) begin
        high = ($urandom_range(99) < 75);
        regime_left = $urandom_range(40, 4);
      end
      regime_left--;
      queue_set(random_set(high));
    end
  endtask

  // Sender: present the next request or hold the current one
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        presented_set = sample_backlog.pop_front();
        in_tdata  <= IN_DATA_W'(presented_set);
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random
  always @(negedge clk) begin
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Predict on each input request, check each result request
  always @(posedge clk) begin
    trigger_result_t got;
    trigger_result_t want;
    in_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pending_results.push_back(advance_trigger(presented_set));
        accepted_items++;
      end
      if (out_tvalid && out_tready) begin
        got.fired            = out_tuser;
        got.awareness_level  = out_tdata[VAL_W-1:0];
        got.trust_average    = out_tdata[2*VAL_W-1:VAL_W];
        got.presence_average = out_tdata[3*VAL_W-1:2*VAL_W];
        got.harmony_average  = out_tdata[4*VAL_W-1:3*VAL_W];
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual fired=%0b level=%0d",
                   $time, got.fired, got.awareness_level);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          report_field("fired", VAL_W'(want.fired), VAL_W'(got.fired));
          report_field("awareness_level", want.awareness_level, got.awareness_level);
          report_field("trust_average", want.trust_average, got.trust_average);
          report_field("presence_average", want.presence_average, got.presence_average);
          report_field("harmony_average", want.harmony_average, got.harmony_average);
        end
      end
      // Watchdog on cycles with no request moving
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_taken   = 1'b0;
    queued_items   = 0;
    accepted_items = 0;
    error_count    = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 6;
    recv_idle_pct  = 56;

    // Reset values of the register set and state
    weight_q      = WEIGHT_DEFAULT;
    trust_min     = TRUST_DEFAULT;
    presence_min  = PRESENCE_DEFAULT;
    harmony_min   = HARMONY_DEFAULT;
    holdoff_len   = REFRACTORY_DEFAULT;
    trust_ema     = '0;
    presence_ema  = '0;
    harmony_ema   = '0;
    ema_primed    = 1'b0;
    warmup_count  = WARMUP_DEFAULT;
    holdoff_count = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: load on the first set, clamp extremes, then ride through
    // warmup into firing and refractory under the default registers
    queue_set(make_set(0, 0, 0, 0));
    queue_set(make_set(-131072, 131071, 65536, 65537));
    queue_set(make_set(65535, -1, 65537, -131072));
    for (int i = 0; i < 19; i++) begin
      case (i % 4)
        0: queue_set(make_set(131071, 65536, 70000, 131071));
        1: queue_set(make_set(65536, 131071, 65537, -1));
        2: queue_set(make_set(100000, 65536, 131071, 65537));
        default: queue_set(make_set(65537, 90000, 65536, 12345));
      endcase
    end

    // Sender lightly idle, receiver heavily stalled
    run_phase(17'd0, 17'd0, 17'd0, 17'd0, 17'd255, 17'd0, 6, 56);
    run_phase(17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd0, 17'd255, 6, 56);
    run_phase(17'd1, 17'd131071, 17'd40000, 17'd30000, 17'd7, 17'd3, 6, 56);
    // Roles swapped
    run_phase(17'd131071, 17'd52429, 17'd45875, 17'd55706, 17'h10000, 17'h1FF02, 56, 6);
    run_phase(17'd30000, 17'd60000, 17'd60000, 17'd60000, 17'd1, 17'd1, 56, 6);
    wait_idle();
    write_reg(REG_SPARE_LO, 17'h1FFFF);
    write_reg(REG_SPARE_HI, 17'd0);
    run_phase(17'd8000, 17'd50000, 17'd45000, 17'd55000, 17'd10, 17'd5, 56, 6);
    // No idling on either side
    run_phase(17'd65535, 17'd20000, 17'd65535, 17'd131071, 17'd128, 17'd0, 0, 0);
    run_phase(17'd16384, 17'd1, 17'd65535, 17'd32768, 17'd254, 17'd255, 0, 0);

    wait_idle();
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/tect_pkg.sv
rtl/core/triple_ema_coincidence_trigger_top.sv
bench/tb_triple_ema_coincidence_trigger_top.sv
